/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the directory record parser.
// Every check is clocked on clk and is off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hdl/isodr_pkg.sv */
// Types and constants of the ISO 9660 directory record parser.
// Used by isodr_capture and iso9660_directory_record_parser_top; no dependencies.
package isodr_pkg;

    // Record header layout, byte offsets from the length byte
    localparam logic [7:0] EXT_ATTR_POS = 8'd1;
    localparam logic [7:0] EXTENT_POS   = 8'd2;
    localparam logic [7:0] SIZE_POS     = 8'd10;
    localparam logic [7:0] DATE_POS     = 8'd18;
    localparam int         DATE_BYTES   = 7;
    localparam logic [7:0] FLAGS_POS    = 8'd25;
    localparam logic [7:0] UNIT_POS     = 8'd26;
    localparam logic [7:0] GAP_POS      = 8'd27;
    localparam logic [7:0] VOLSEQ_POS   = 8'd28;
    localparam logic [7:0] NAMELEN_POS  = 8'd32;
    localparam logic [7:0] HDR_LEN      = 8'd33;

    localparam logic [11:0] DEFAULT_BLOCK = 12'd2048;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_CUT = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_SELF   = 2'd1;
    localparam logic [1:0] KIND_PARENT = 2'd2;

    // Header fields of the record in progress
    typedef struct packed {
        logic [7:0]  ext_attr;
        logic [31:0] extent;
        logic [31:0] size;
        logic [55:0] date;
        logic [7:0]  flags;
        logic [7:0]  unit_size;
        logic [7:0]  gap;
        logic [15:0] volseq;
        logic [7:0]  namelen;
        logic [7:0]  first_name;
    } isodr_fields_t;

    // Capture control from the record sequencer
    typedef struct packed {
        logic       capture;  // byte belongs to a record and is accepted
        logic       start;    // byte is the length byte of a new record
        logic [7:0] idx;      // byte offset within the record
    } isodr_cap_ctrl_t;

endpackage

/* hdl/isodr_capture.sv */
// Header field capture of the directory record parser: one byte lane per offset.
// Depends on isodr_pkg.
module isodr_capture (
    input  logic                        clk,
    input  logic                        rst_n,
    input  isodr_pkg::isodr_cap_ctrl_t  ctrl,
    input  logic [7:0]                  data_byte,
    output isodr_pkg::isodr_fields_t    fields_next
);

    isodr_pkg::isodr_fields_t fields_reg;

    always_comb
    begin
        // clear at the length byte so a short record reports unreached fields as zero
        fields_next = ctrl.start ? '0 : fields_reg;
        if (ctrl.idx == isodr_pkg::EXT_ATTR_POS)
            fields_next.ext_attr = data_byte;
        for (int k = 0; k < 4; k++)
        begin
            if (ctrl.idx == isodr_pkg::EXTENT_POS + 8'(k))
                fields_next.extent[8*k +: 8] = data_byte;
            if (ctrl.idx == isodr_pkg::SIZE_POS + 8'(k))
                fields_next.size[8*k +: 8] = data_byte;
        end
        for (int k = 0; k < isodr_pkg::DATE_BYTES; k++)
        begin
            if (ctrl.idx == isodr_pkg::DATE_POS + 8'(k))
                fields_next.date[8*k +: 8] = data_byte;
        end
        if (ctrl.idx == isodr_pkg::FLAGS_POS)
            fields_next.flags = data_byte;
        if (ctrl.idx == isodr_pkg::UNIT_POS)
            fields_next.unit_size = data_byte;
        if (ctrl.idx == isodr_pkg::GAP_POS)
            fields_next.gap = data_byte;
        for (int k = 0; k < 2; k++)
        begin
            if (ctrl.idx == isodr_pkg::VOLSEQ_POS + 8'(k))
                fields_next.volseq[8*k +: 8] = data_byte;
        end
        if (ctrl.idx == isodr_pkg::NAMELEN_POS)
            fields_next.namelen = data_byte;
        if (ctrl.idx == isodr_pkg::HDR_LEN)
            fields_next.first_name = data_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fields_reg <= '0;
        else if (ctrl.capture)
            fields_reg <= fields_next;
    end

endmodule

/* hdl/iso9660_directory_record_parser_top.sv */
// ISO 9660 directory record parser, top level: record sequencer, padding skip and result register.
// Depends on isodr_pkg, isodr_capture and assert_macros.svh.
//
// Takes one byte of a directory extent per cycle and gives one item per finished
// record, loaded into the result register with its last byte; a record cut off by last_byte
// gives an item with status 1 and only record_length set. Throughput is one byte per cycle: each
// byte updates the position counters and at most one header field lane, and the only hold-off
// is a result waiting in the output register while out_stall is high. block_size may be written
// only while idle; 0 acts as 2048.
`include "assert_macros.svh"

module iso9660_directory_record_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_data,
    // byte stream
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // record results
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [7:0]  record_length,
    output logic [7:0]  ext_attr_length,
    output logic [31:0] extent_location,
    output logic [31:0] data_length,
    output logic [55:0] recording_time,
    output logic [7:0]  file_flags,
    output logic [7:0]  file_unit_size,
    output logic [7:0]  interleave_gap,
    output logic [15:0] volume_sequence,
    output logic [7:0]  name_length,
    output logic [1:0]  name_kind
);

    logic [11:0] block_size_reg;
    logic [7:0]  rec_pos_reg, rec_pos_next;
    logic [7:0]  rec_len_reg, rec_len_next;
    logic [11:0] block_pos_reg, block_pos_next;
    logic        skip_reg, skip_next;
    logic        out_valid_reg;

    logic        accept;
    logic [11:0] bs;
    logic        end_blk;
    logic        emit_ok;
    logic        emit_cut;
    logic        in_record;
    logic [1:0]  kind;

    isodr_pkg::isodr_cap_ctrl_t ctrl;
    isodr_pkg::isodr_fields_t   fields_next;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;

    assign bs      = (block_size_reg == '0) ? isodr_pkg::DEFAULT_BLOCK : block_size_reg;
    assign end_blk = ({1'b0, block_pos_reg} + 13'd1) >= {1'b0, bs};

    always_comb
    begin
        skip_next    = skip_reg;
        rec_pos_next = rec_pos_reg;
        rec_len_next = rec_len_reg;
        in_record    = 1'b0;
        emit_ok      = 1'b0;
        if (skip_reg)
        begin
            if (end_blk)
                skip_next = 1'b0;
        end
        else if (rec_pos_reg == '0 && data_byte == '0)
        begin
            // zero length byte: pad out the rest of the block
            if (!end_blk)
                skip_next = 1'b1;
        end
        else
        begin
            in_record = 1'b1;
            if (rec_pos_reg == '0)
                rec_len_next = data_byte;
            if (({1'b0, rec_pos_reg} + 9'd1) >= {1'b0, rec_len_next})
            begin
                emit_ok      = 1'b1;
                rec_pos_next = '0;
            end
            else
            begin
                rec_pos_next = rec_pos_reg + 8'd1;
            end
        end

        emit_cut = last_byte & ~emit_ok & (rec_pos_next != '0);

        if (last_byte)
        begin
            rec_pos_next   = '0;
            block_pos_next = '0;
            skip_next      = 1'b0;
        end
        else
        begin
            block_pos_next = end_blk ? '0 : block_pos_reg + 12'd1;
        end
    end

    always_comb
    begin
        ctrl.capture = accept & in_record;
        ctrl.start   = in_record & (rec_pos_reg == '0);
        ctrl.idx     = rec_pos_reg;
    end

    isodr_capture u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .data_byte   (data_byte),
        .fields_next (fields_next)
    );

    always_comb
    begin
        kind = isodr_pkg::KIND_NONE;
        if (fields_next.namelen == 8'd1 && rec_len_next > isodr_pkg::HDR_LEN)
        begin
            if (fields_next.first_name == 8'd0)
                kind = isodr_pkg::KIND_SELF;
            else if (fields_next.first_name == 8'd1)
                kind = isodr_pkg::KIND_PARENT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_reg <= isodr_pkg::DEFAULT_BLOCK;
            rec_pos_reg    <= '0;
            rec_len_reg    <= '0;
            block_pos_reg  <= '0;
            skip_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                block_size_reg <= cfg_data;
            if (accept)
            begin
                rec_pos_reg   <= rec_pos_next;
                rec_len_reg   <= rec_len_next;
                block_pos_reg <= block_pos_next;
                skip_reg      <= skip_next;
            end
            if (accept && (emit_ok || emit_cut))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // result register: load a parsed record, or a cut-off record with only its length
    always_ff @(posedge clk)
    begin
        if (accept && (emit_ok || emit_cut))
        begin
            record_length <= rec_len_next;
            if (emit_ok)
            begin
                status          <= isodr_pkg::STATUS_OK;
                ext_attr_length <= fields_next.ext_attr;
                extent_location <= fields_next.extent;
                data_length     <= fields_next.size;
                recording_time  <= fields_next.date;
                file_flags      <= fields_next.flags;
                file_unit_size  <= fields_next.unit_size;
                interleave_gap  <= fields_next.gap;
                volume_sequence <= fields_next.volseq;
                name_length     <= fields_next.namelen;
                name_kind       <= kind;
            end
            else
            begin
                status          <= isodr_pkg::STATUS_CUT;
                ext_attr_length <= '0;
                extent_location <= '0;
                data_length     <= '0;
                recording_time  <= '0;
                file_flags      <= '0;
                file_unit_size  <= '0;
                interleave_gap  <= '0;
                volume_sequence <= '0;
                name_length     <= '0;
                name_kind       <= isodr_pkg::KIND_NONE;
            end
        end
    end

    `ASSERT_NEVER(a_skip_in_record, skip_reg && rec_pos_reg != '0, "padding skip inside a record")
    `ASSERT_CLK(a_pos_below_len, rec_pos_reg != '0 |-> rec_pos_reg < rec_len_reg, "record position past length")
    `ASSERT_CLK(a_last_resets, accept && last_byte |=> rec_pos_reg == '0 && block_pos_reg == '0 && !skip_reg, "extent end did not reset position")
    `ASSERT_CLK(a_cut_zero, out_valid && status == isodr_pkg::STATUS_CUT |-> extent_location == '0 && data_length == '0 && name_kind == isodr_pkg::KIND_NONE, "cut-off item carries fields")
    `ASSERT_CLK(a_kind_cond, out_valid && name_kind != isodr_pkg::KIND_NONE |-> name_length == 8'd1 && record_length > isodr_pkg::HDR_LEN, "self or parent mark on wrong record")

endmodule
